// ===== rtl/kclp_pkg.sv =====
// Package with the word types, phase encoding and character constants of the list parser.
`timescale 1ns / 1ps

package kclp_pkg;

  // Input word: one text character or the end-of-text command.
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } kclp_in_t;

  // Result word: one closed record.
  typedef struct packed {
    logic        record_ok;
    logic [31:0] entry_id;
    logic [31:0] amount;
    logic        list_done;
  } kclp_out_t;

  // Position inside the current record.
  typedef enum logic [2:0] {
    PH_PRE_ENTRY  = 3'd0,
    PH_ENTRY      = 3'd1,
    PH_POST_ENTRY = 3'd2,
    PH_PRE_COUNT  = 3'd3,
    PH_COUNT      = 3'd4,
    PH_POST_COUNT = 3'd5,
    PH_BAD        = 3'd6
  } kclp_phase_t;

  // Command codes.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Saturation limit of both decimal fields.
  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

endpackage

// ===== rtl/kclp_digit_acc.sv =====
// Decimal digit accumulator: acc * 10 + digit, saturating at the 32-bit maximum.
`timescale 1ns / 1ps

module kclp_digit_acc (
  input  logic [31:0] acc,
  input  logic [3:0]  digit,
  output logic [31:0] acc_next
);
  import kclp_pkg::*;

  logic [35:0] wide_acc;
  logic [35:0] sum;

  // Times ten as two shifted copies, then add the digit.
  always_comb begin
    wide_acc = {4'b0000, acc};
    sum      = (wide_acc << 3) + (wide_acc << 1) + {32'd0, digit};
    if (|sum[35:32]) begin
      acc_next = SAT_MAX;
    end else begin
      acc_next = sum[31:0];
    end
  end

endmodule

// ===== rtl/key_count_list_parser_unit.sv =====
// Top level of the entry:count list parser with input register and result register.
// A word that closes a record passes through the input register and then, when the parse
// stage advances, into the result register, from which the result handshake takes it.
// Throughput: one character word per cycle while the result side keeps taking words;
// the limit is the single parse stage that updates phase and accumulators per character.
// Reset (rst, synchronous, active high) empties both registers and returns the parser
// to the start of a record with both accumulators at zero.
`timescale 1ns / 1ps

module key_count_list_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kclp_pkg::kclp_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kclp_pkg::kclp_out_t out_data
);
  import kclp_pkg::*;

  // Input register.
  logic        s1_valid;
  kclp_in_t    s1_data;

  // Record state.
  kclp_phase_t phase;
  kclp_phase_t phase_next;
  logic [31:0] entry_accum;
  logic [31:0] entry_accum_next;
  logic [31:0] count_accum;
  logic [31:0] count_accum_next;

  // Character decode and handshake control.
  logic        is_close;
  logic        is_ws;
  logic        is_digit;
  logic        is_colon;
  logic        in_count;
  logic        s1_advance;
  logic        out_load;
  logic        rec_ok;
  logic [31:0] acc_in;
  logic [31:0] acc_out;
  kclp_out_t   result;

  // Decode the registered character.
  always_comb begin
    is_close = (s1_data.cmd == CMD_END) || (s1_data.ch == CH_COMMA);
    is_ws    = ((s1_data.ch >= CH_TAB) && (s1_data.ch <= CH_CR)) || (s1_data.ch == CH_SPACE);
    is_digit = (s1_data.ch >= CH_ZERO) && (s1_data.ch <= CH_NINE);
    is_colon = (s1_data.ch == CH_COLON);
    in_count = (phase == PH_PRE_COUNT) || (phase == PH_COUNT);
  end

  // The stage moves on unless it must write a result into a full result register that is not being read out.
  assign s1_advance = s1_valid && (!is_close || !out_valid || out_ready);
  assign out_load   = s1_advance && is_close;
  assign in_ready   = !s1_valid || s1_advance;

  // One shared accumulator for whichever field is being read.
  assign acc_in = in_count ? count_accum : entry_accum;

  kclp_digit_acc u_acc (
    .acc      (acc_in),
    .digit    (s1_data.ch[3:0]),
    .acc_next (acc_out)
  );

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (is_close) begin
      phase_next = PH_PRE_ENTRY;
    end else if (is_ws) begin
      case (phase)
        PH_ENTRY: phase_next = PH_POST_ENTRY;
        PH_COUNT: phase_next = PH_POST_COUNT;
        default:  phase_next = phase;
      endcase
    end else if (is_digit) begin
      case (phase)
        PH_PRE_ENTRY, PH_ENTRY: phase_next = PH_ENTRY;
        PH_PRE_COUNT, PH_COUNT: phase_next = PH_COUNT;
        default:                phase_next = PH_BAD;
      endcase
    end else if (is_colon) begin
      case (phase)
        PH_ENTRY, PH_POST_ENTRY: phase_next = PH_PRE_COUNT;
        default:                 phase_next = PH_BAD;
      endcase
    end else begin
      phase_next = PH_BAD;
    end
  end

  // Accumulators and the result word.
  always_comb begin
    entry_accum_next = entry_accum;
    count_accum_next = count_accum;
    rec_ok = ((phase == PH_COUNT) || (phase == PH_POST_COUNT)) && (count_accum != 32'd0);
    result.record_ok = rec_ok;
    result.entry_id  = rec_ok ? entry_accum : 32'd0;
    result.amount    = rec_ok ? count_accum : 32'd0;
    result.list_done = s1_data.cmd;
    if (is_close) begin
      entry_accum_next = 32'd0;
      count_accum_next = 32'd0;
    end else if (is_digit && !is_ws) begin
      if ((phase == PH_PRE_ENTRY) || (phase == PH_ENTRY)) begin
        entry_accum_next = acc_out;
      end else if (in_count) begin
        count_accum_next = acc_out;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PRE_ENTRY;
      entry_accum <= 32'd0;
      count_accum <= 32'd0;
    end else if (s1_advance) begin
      phase       <= phase_next;
      entry_accum <= entry_accum_next;
      count_accum <= count_accum_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/kclp_checker.sv =====
// Port-level checker for the list parser and its bind to the top level.
`timescale 1ns / 1ps

module kclp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input kclp_pkg::kclp_out_t out_data
);
  import kclp_pkg::*;

  // A result word that is not taken stays in place.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A rejected record carries zero fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.record_ok |-> out_data.entry_id == 32'd0 && out_data.amount == 32'd0)
    else $error("rejected record has nonzero fields");

  // An accepted record always has a nonzero count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_ok |-> out_data.amount != 32'd0)
    else $error("accepted record has zero count");

  // Nothing is offered right after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind key_count_list_parser_unit kclp_checker u_kclp_checker (.*);

// ===== sim/tb.sv =====
// Testbench for the entry:count list parser: directed and random texts checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import kclp_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  kclp_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  kclp_out_t out_data;

  // Expected results in order, one per comma or end of text.
  kclp_out_t   pending_records[$];
  // Predictor state for the record being parsed.
  kclp_phase_t pred_phase;
  logic [31:0] pred_entry;
  logic [31:0] pred_count;
  // Characters of the record under construction.
  logic [7:0]  rec_chars[$];

  int  mismatches = 0;
  int  words_sent = 0;
  // When set, neither side inserts idle cycles.
  bit  calm = 1'b0;

  key_count_list_parser_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Adds one character at the end of the record under construction.
  function automatic void append_char(input logic [7:0] c);
    rec_chars.insert(rec_chars.size(), c);
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  // Multiply by ten and add one decimal digit, saturating at the 32-bit maximum.
  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [63:0] v;
    v = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
    return (v > {32'd0, SAT_MAX}) ? SAT_MAX : v[31:0];
  endfunction

  // Advances the predictor by one accepted word and queues any closed record.
  task automatic parse_char(input kclp_in_t w);
    kclp_out_t r;
    logic      ok;
    if (w.cmd == CMD_END || w.ch == CH_COMMA) begin
      ok = (pred_phase == PH_COUNT || pred_phase == PH_POST_COUNT) && pred_count != 32'd0;
      r.record_ok = ok;
      r.entry_id  = ok ? pred_entry : 32'd0;
      r.amount    = ok ? pred_count : 32'd0;
      r.list_done = w.cmd;
      pending_records.insert(pending_records.size(), r);
      pred_phase = PH_PRE_ENTRY;
      pred_entry = 32'd0;
      pred_count = 32'd0;
    end else if (is_space(w.ch)) begin
      if (pred_phase == PH_ENTRY) pred_phase = PH_POST_ENTRY;
      else if (pred_phase == PH_COUNT) pred_phase = PH_POST_COUNT;
    end else if (w.ch >= CH_ZERO && w.ch <= CH_NINE) begin
      if (pred_phase == PH_PRE_ENTRY || pred_phase == PH_ENTRY) begin
        pred_entry = add_digit(pred_entry, w.ch);
        pred_phase = PH_ENTRY;
      end else if (pred_phase == PH_PRE_COUNT || pred_phase == PH_COUNT) begin
        pred_count = add_digit(pred_count, w.ch);
        pred_phase = PH_COUNT;
      end else begin
        pred_phase = PH_BAD;
      end
    end else if (w.ch == CH_COLON) begin
      if (pred_phase == PH_ENTRY || pred_phase == PH_POST_ENTRY) pred_phase = PH_PRE_COUNT;
      else pred_phase = PH_BAD;
    end else begin
      pred_phase = PH_BAD;
    end
  endtask

  // Sends one word. Starts and ends at a falling edge.
  task automatic send_word(input logic cmd, input logic [7:0] ch);
    kclp_in_t w;
    int       gap;
    w.cmd = cmd;
    w.ch  = ch;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    parse_char(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_CHAR, s[i]);
  endtask

  // Appends zero or a few whitespace characters.
  task automatic add_space;
    int n;
    int k;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      k = $urandom_range(0, 5);
      append_char(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
    end
  endtask

  // Appends a decimal field; mostly short, sometimes long enough to saturate.
  task automatic add_digits;
    int r;
    int len;
    r = $urandom_range(0, 15);
    len = (r < 10) ? $urandom_range(1, 3) : (r < 14) ? $urandom_range(4, 9)
                                                    : $urandom_range(10, 12);
    repeat (len) append_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Builds and sends one random record followed by a comma or end of text.
  task automatic send_random_record;
    int kind;
    int pos;
    rec_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 8) begin
      add_space();
      add_digits();
      add_space();
      append_char(CH_COLON);
      add_space();
      add_digits();
      add_space();
    end else begin
      repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
    end
    // Break a well-formed record in one of several ways.
    if (kind == 7 || kind == 8) begin
      pos = $urandom_range(0, rec_chars.size() - 1);
      case ($urandom_range(0, 3))
        0: rec_chars[pos] = 8'($urandom_range(0, 255));
        1: rec_chars.insert(pos, 8'($urandom_range(0, 255)));
        2: rec_chars.delete(pos);
        default: rec_chars.insert(pos, CH_COLON);
      endcase
    end
    foreach (rec_chars[i]) send_word(CMD_CHAR, rec_chars[i]);
    if ($urandom_range(0, 7) == 0) send_word(CMD_END, 8'($urandom_range(0, 255)));
    else send_word(CMD_CHAR, CH_COMMA);
  endtask

  // Result side: random stall before each word, then check it against the oldest expectation.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1 || rst);
    end
  end

  always @(posedge clk) begin
    kclp_out_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        exp_r = pending_records.pop_front();
        if (out_data.record_ok !== exp_r.record_ok)
          report_mismatch($sformatf("record_ok got %b want %b",
                                    out_data.record_ok, exp_r.record_ok));
        if (out_data.entry_id !== exp_r.entry_id)
          report_mismatch($sformatf("entry_id got %0d want %0d",
                                    out_data.entry_id, exp_r.entry_id));
        if (out_data.amount !== exp_r.amount)
          report_mismatch($sformatf("amount got %0d want %0d",
                                    out_data.amount, exp_r.amount));
        if (out_data.list_done !== exp_r.list_done)
          report_mismatch($sformatf("list_done got %b want %b",
                                    out_data.list_done, exp_r.list_done));
      end
    end
  end

  // Empty text, empty records, whitespace, saturation, zero count and a second colon.
  task automatic test_directed;
    send_word(CMD_END, 8'h00);
    send_text(",,");
    send_text(" 7:\t4 ,");
    send_text("9999999999:1,");
    send_text("3:0,");
    send_text("1:2:3");
    send_word(CMD_END, CH_COMMA);
  endtask

  task automatic test_random_lists(input int word_limit);
    while (words_sent < word_limit) send_random_record();
  endtask

  // Back-to-back words with no idle cycles on either side.
  task automatic test_full_rate(input int word_limit);
    calm = 1'b1;
    while (words_sent < word_limit) send_random_record();
    calm = 1'b0;
  endtask

  // Now and then hold the input until every expected result has come, then resume.
  task automatic test_drain_pause(input int word_limit);
    while (words_sent < word_limit) begin
      send_random_record();
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        wait (pending_records.size() == 0);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    pred_phase = PH_PRE_ENTRY;
    pred_entry = 32'd0;
    pred_count = 32'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_lists(1250);
    test_full_rate(1500);
    test_drain_pause(1650);

    in_valid <= 1'b0;
    wait (pending_records.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kclp_pkg.sv
rtl/kclp_digit_acc.sv
rtl/key_count_list_parser_unit.sv
rtl/kclp_checker.sv
sim/tb.sv
